@@ rtl/tick_phase_tracking_loop_core_defines.svh @@
// assertion macros for the checker of the tick phase tracking loop
`ifndef TICK_PHASE_TRACKING_LOOP_CORE_DEFINES_SVH
`define TICK_PHASE_TRACKING_LOOP_CORE_DEFINES_SVH

// same-cycle implication
`define TPLL_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tpll assertion failed");

// next-cycle implication
`define TPLL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tpll assertion failed");

`endif

@@ rtl/tpll_pkg.sv @@
package tpll_pkg;

   localparam int TIME_W    = 32;
   localparam int NOMINAL_W = 20;

   localparam logic [NOMINAL_W-1:0] NOMINAL_RESET = 20'd20833;

   // ceil(2^34 / 5), exact floor(x / 5) for any 32-bit x after >> 34
   localparam logic [31:0] RECIP_5 = 32'hCCCC_CCCD;

endpackage

@@ rtl/tick_phase_tracking_loop_core.sv @@
// Tick phase tracking loop. Each req_ word carries the microsecond arrival time of one
// incoming clock tick and produces exactly one rsp_ word: the interval now in use, the
// wrapped lateness of the tick against the expected time and a flag for a tick that only
// set the phase reference (expected time zero means unlocked; it is zero after reset and
// again whenever it wraps to zero). The block sustains one word per clock while rsp_ready
// is high. The clock is bounded by the combinational loop from the input register through
// error, low-pass filter (one 32x32 multiply by the reciprocal of five), gain and interval
// back into the expected-time register. A csr_ write loads the nominal interval and the
// current interval and is to be made while no word is in flight.
module tick_phase_tracking_loop_core
   import tpll_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [TIME_W-1:0]    req_tick_time_us,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [TIME_W-1:0]    rsp_interval_us,
   output logic signed [TIME_W-1:0] rsp_phase_error_us,
   output logic                 rsp_was_first_tick,
   input  logic                 csr_wr_en,
   input  logic [NOMINAL_W-1:0] csr_wr_data
);

   logic                 in_valid_ff;
   logic [TIME_W-1:0]    tick_ff;
   logic                 out_valid_ff;
   logic [TIME_W-1:0]    out_interval_ff, out_interval_in;
   logic [TIME_W-1:0]    out_error_ff, out_error_in;
   logic                 out_first_ff, out_first_in;

   logic [NOMINAL_W-1:0] nominal_ff;
   logic [TIME_W-1:0]    expected_ff, expected_in;
   logic [TIME_W-1:0]    filtered_ff, filtered_in;
   logic [TIME_W-1:0]    interval_ff, interval_in;

   logic                 advance;
   logic [TIME_W-1:0]    err;
   logic [TIME_W:0]      diff;
   logic [TIME_W:0]      mag;
   logic [TIME_W-2:0]    quarter;
   logic [63:0]          prod;
   logic [29:0]          q5;
   logic [TIME_W-1:0]    step;
   logic [TIME_W-1:0]    filt_new;
   logic [TIME_W-1:0]    biased;
   logic [TIME_W-1:0]    corr;
   logic [TIME_W-1:0]    interval_new;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      err  = tick_ff - expected_ff;
      diff = {err[TIME_W-1], err} - {filtered_ff[TIME_W-1], filtered_ff};
      mag  = diff[TIME_W] ? (~diff + 33'd1) : diff;
      // divide by 20: drop two bits, then floor divide by five
      quarter = mag[TIME_W:2];
      prod    = {1'b0, quarter} * RECIP_5;
      q5      = prod[63:34];
      step    = diff[TIME_W] ? (~{2'b00, q5} + 32'd1) : {2'b00, q5};
      filt_new = filtered_ff + step;
      // divide by 8 toward zero
      biased = filt_new + (filt_new[TIME_W-1] ? 32'd7 : 32'd0);
      corr   = {{3{biased[TIME_W-1]}}, biased[TIME_W-1:3]};
      interval_new = {{(TIME_W-NOMINAL_W){1'b0}}, nominal_ff} + corr;

      if (expected_ff == '0) begin
         expected_in     = tick_ff + interval_ff;
         filtered_in     = filtered_ff;
         interval_in     = interval_ff;
         out_interval_in = interval_ff;
         out_error_in    = '0;
         out_first_in    = 1'b1;
      end else begin
         expected_in     = expected_ff + interval_new;
         filtered_in     = filt_new;
         interval_in     = interval_new;
         out_interval_in = interval_new;
         out_error_in    = err;
         out_first_in    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         nominal_ff   <= NOMINAL_RESET;
         expected_ff  <= '0;
         filtered_ff  <= '0;
         interval_ff  <= {{(TIME_W-NOMINAL_W){1'b0}}, NOMINAL_RESET};
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
         if (csr_wr_en) begin
            nominal_ff  <= csr_wr_data;
            interval_ff <= {{(TIME_W-NOMINAL_W){1'b0}}, csr_wr_data};
         end else if (advance) begin
            interval_ff <= interval_in;
         end
         if (advance) begin
            expected_ff <= expected_in;
            filtered_ff <= filtered_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         tick_ff <= req_tick_time_us;
      end
      if (advance) begin
         out_interval_ff <= out_interval_in;
         out_error_ff    <= out_error_in;
         out_first_ff    <= out_first_in;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_interval_us    = out_interval_ff;
   assign rsp_phase_error_us = out_error_ff;
   assign rsp_was_first_tick = out_first_ff;

endmodule

@@ rtl/tpll_checker.sv @@
`include "tick_phase_tracking_loop_core_defines.svh"

module tpll_checker
   import tpll_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [TIME_W-1:0]    rsp_interval_us,
   input logic signed [TIME_W-1:0] rsp_phase_error_us,
   input logic                 rsp_was_first_tick
);

   logic              req_take;
   logic [2*TIME_W:0] rsp_word;

   assign req_take = req_valid && req_ready;
   assign rsp_word = {rsp_interval_us, rsp_phase_error_us, rsp_was_first_tick};

   // a stalled result word holds
   `TPLL_ASSERT_NEXT(rsp_hold_a, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_word))

   // a reference-only tick reports no lateness
   `TPLL_ASSERT_NOW(first_zero_a, clock, reset, rsp_valid && rsp_was_first_tick, rsp_phase_error_us == '0)

   // reset leaves nothing to deliver
   `TPLL_ASSERT_NEXT(reset_empty_a, clock, 1'b0, reset, !rsp_valid && req_ready)

   // a word taken by the input stage cannot be on the result side the next cycle
   `TPLL_ASSERT_NEXT(min_latency_a, clock, reset, !rsp_valid && !req_take && req_ready, !rsp_valid || $past(req_take, 2))

endmodule

bind tick_phase_tracking_loop_core tpll_checker u_tpll_checker (.*);
